// ===== rtl/mrd_pkg.sv =====
// ----------------------------------------------------------------------------
// mrd_pkg: shared types, constants and the CRC step of the response deframer
// Holds the frame kind codes, frame length limits, register indexes and the
// byte-wise CRC-16 update (reflected polynomial 0xA001).
// ----------------------------------------------------------------------------
package mrd_pkg;

    // Field widths
    localparam int ByteW      = 8;
    localparam int CrcW       = 16;
    localparam int CountW     = 11;
    localparam int IdleW      = 16;
    localparam int KindW      = 3;
    localparam int CfgW       = 16;
    localparam int CfgIndexW  = 2;
    localparam int HeaderN    = 6;
    localparam int HeaderIdxW = 3;
    localparam int OutDataW   = 72;

    // CRC and frame constants
    localparam logic [CrcW-1:0]   CrcInit   = 16'hFFFF;
    localparam logic [CrcW-1:0]   CrcPoly   = 16'hA001;
    localparam logic [CountW-1:0] LenMeter  = 11'd205;
    localparam logic [CountW-1:0] LenPoll   = 11'd41;
    localparam logic [CountW-1:0] LenEcho   = 11'd8;
    localparam logic [CountW-1:0] CountMax  = 11'd2047;
    localparam logic [CountW-1:0] MinFrame  = 11'd3;
    localparam logic [IdleW-1:0]  IdleMax   = 16'hFFFF;
    localparam logic [ByteW-1:0]  FuncRead  = 8'd3;
    localparam logic [ByteW-1:0]  FuncWrite = 8'd6;

    // Register reset values
    localparam logic [IdleW-1:0]  IdleTimeoutReset = 16'd2000;
    localparam logic [CountW-1:0] OverflowReset    = 11'd1000;
    localparam logic [CountW-1:0] LongFrameReset   = 11'd100;

    // Configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        REG_IDLE_TIMEOUT = 2'd0,
        REG_OVERFLOW     = 2'd1,
        REG_LONG_FRAME   = 2'd2
    } cfg_reg_t;

    // Input word kinds
    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } command_t;

    // Frame kinds reported on the result channel
    typedef enum logic [KindW-1:0] {
        KIND_METER   = 3'd0,
        KIND_POLL    = 3'd1,
        KIND_ECHO    = 3'd2,
        KIND_BAD_LEN = 3'd3,
        KIND_UNKNOWN = 3'd4
    } frame_kind_t;

    // One decoded response
    typedef struct packed {
        frame_kind_t       frame_kind;
        logic [ByteW-1:0]  slave_address;
        logic [ByteW-1:0]  function_code;
        logic [CountW-1:0] frame_length;
        logic [15:0]       station_word;
        logic [ByteW-1:0]  register_index;
        logic [15:0]       register_value;
    } frame_result_t;

    // Configuration values handed to the frame tracker
    typedef struct packed {
        logic [IdleW-1:0]  idle_timeout;
        logic [CountW-1:0] overflow_limit;
        logic [CountW-1:0] long_threshold;
    } frame_cfg_t;

    // Fold one byte into the running CRC, one bit per step
    function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                                 input logic [ByteW-1:0] data);
        logic [CrcW-1:0] crc;
        crc = crc_in ^ {{(CrcW-ByteW){1'b0}}, data};
        for (int i = 0; i < ByteW; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CrcPoly;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/mrd_in_reg.sv =====
// ----------------------------------------------------------------------------
// mrd_in_reg: input word register
// Captures one input word and holds it until the frame stage takes it.
// ----------------------------------------------------------------------------
module mrd_in_reg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [mrd_pkg::ByteW-1:0] s_tdata,
    input  logic                      s_tuser,
    input  logic                      take,
    output logic                      word_valid,
    output logic [mrd_pkg::ByteW-1:0] word_byte,
    output logic                      word_cmd
);
    import mrd_pkg::*;

    logic             valid_reg, valid_next;
    logic [ByteW-1:0] byte_reg;
    logic             cmd_reg;

    // Accept when empty or when the held word leaves this cycle
    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload of the accepted word
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            cmd_reg  <= s_tuser;
        end
    end

    assign word_valid = valid_reg;
    assign word_byte  = byte_reg;
    assign word_cmd   = cmd_reg;

endmodule

// ===== rtl/mrd_frame.sv =====
// ----------------------------------------------------------------------------
// mrd_frame: frame tracker
// Keeps the running CRC, byte count, idle count and header bytes, and
// classifies a frame of over three bytes once its CRC residue is zero.
// ----------------------------------------------------------------------------
module mrd_frame (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [mrd_pkg::ByteW-1:0]  word_byte,
    input  logic                       word_cmd,
    input  mrd_pkg::frame_cfg_t        cfg,
    output logic                       res_valid,
    output mrd_pkg::frame_result_t     result
);
    import mrd_pkg::*;

    logic [CrcW-1:0]   crc_reg, crc_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [IdleW-1:0]  idle_reg, idle_next;
    logic [ByteW-1:0]  hdr_reg [HeaderN];
    logic [ByteW-1:0]  hdr_next [HeaderN];

    logic [CrcW-1:0]   crc_step;
    logic [CountW-1:0] count_step;
    logic [IdleW-1:0]  idle_step;
    logic              frame_done;
    logic [ByteW-1:0]  hb3, hb4, hb5;
    frame_kind_t       kind;

    // Byte path: CRC, count and header write
    always_comb begin
        crc_step   = crc_byte(crc_reg, word_byte);
        count_step = (count_reg < CountMax) ? count_reg + 11'd1 : count_reg;
        idle_step  = (idle_reg < IdleMax) ? idle_reg + 16'd1 : idle_reg;
        for (int i = 0; i < HeaderN; i++) begin
            hdr_next[i] = hdr_reg[i];
            if (count_reg == CountW'(i)) begin
                hdr_next[i] = word_byte;
            end
        end
    end

    assign frame_done = step && (word_cmd == CMD_BYTE) &&
                        (count_step > MinFrame) && (crc_step == '0);

    // Next state of the tracker
    always_comb begin
        crc_next   = crc_reg;
        count_next = count_reg;
        idle_next  = idle_reg;
        if (step) begin
            if (word_cmd == CMD_TICK) begin
                if (count_reg != '0) begin
                    if (idle_step >= cfg.idle_timeout) begin
                        crc_next   = CrcInit;
                        count_next = '0;
                        idle_next  = '0;
                    end else begin
                        idle_next = idle_step;
                    end
                end
            end else if (frame_done || (count_step > cfg.overflow_limit)) begin
                crc_next   = CrcInit;
                count_next = '0;
                idle_next  = '0;
            end else begin
                crc_next   = crc_step;
                count_next = count_step;
                idle_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= CrcInit;
            count_reg <= '0;
            idle_reg  <= '0;
        end else begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            idle_reg  <= idle_next;
        end
    end

    // Header bytes are written only on byte words
    always_ff @(posedge aclk) begin
        if (step && (word_cmd == CMD_BYTE)) begin
            for (int i = 0; i < HeaderN; i++) begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

    // Header bytes past the frame end read as zero
    assign hb3 = (count_step > 11'd3) ? hdr_next[3] : '0;
    assign hb4 = (count_step > 11'd4) ? hdr_next[4] : '0;
    assign hb5 = (count_step > 11'd5) ? hdr_next[5] : '0;

    // Sort the frame by function code and length
    always_comb begin
        if (hdr_next[1] == FuncRead) begin
            if (count_step > cfg.long_threshold) begin
                kind = (count_step == LenMeter) ? KIND_METER : KIND_BAD_LEN;
            end else begin
                kind = (count_step == LenPoll) ? KIND_POLL : KIND_BAD_LEN;
            end
        end else if (hdr_next[1] == FuncWrite) begin
            kind = (count_step == LenEcho) ? KIND_ECHO : KIND_BAD_LEN;
        end else begin
            kind = KIND_UNKNOWN;
        end
    end

    assign res_valid = frame_done;

    always_comb begin
        result.frame_kind     = kind;
        result.slave_address  = hdr_next[0];
        result.function_code  = hdr_next[1];
        result.frame_length   = count_step;
        result.station_word   = {hb3, hb4};
        result.register_index = hb3;
        result.register_value = {hb4, hb5};
    end

endmodule

// ===== rtl/mrd_out_reg.sv =====
// ----------------------------------------------------------------------------
// mrd_out_reg: result register
// Holds one decoded response until the downstream side takes it.
// ----------------------------------------------------------------------------
module mrd_out_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  mrd_pkg::frame_result_t       result,
    output logic                         busy,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mrd_pkg::OutDataW-1:0] m_tdata
);
    import mrd_pkg::*;

    logic          valid_reg, valid_next;
    frame_result_t data_reg;

    // Busy while a result waits and is not taken this cycle
    assign busy = valid_reg && !m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    // Pack fields, first field in the lowest bits
    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00,
                       data_reg.register_value,
                       data_reg.register_index,
                       data_reg.station_word,
                       data_reg.frame_length,
                       data_reg.function_code,
                       data_reg.slave_address,
                       data_reg.frame_kind};

endmodule

// ===== rtl/modbus_rtu_response_deframer.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_response_deframer: Modbus RTU response receiver with CRC-16
// Accumulates received bytes and idle ticks into a response frame, checks
// the CRC after every byte and reports the kind and header of each frame.
//
//   channel  direction  handshake           payload
//   s_       in         s_tvalid/s_tready   tdata rx_byte, tuser command
//   m_       out        m_tvalid/m_tready   tdata decoded response
//   cfg_     in         cfg_we              cfg_index, cfg_wdata
//
// One word per cycle while no untaken result stalls the frame stage; an accepted
// word waits in the input register while the CRC/count update in mrd_frame runs,
// and the result register then loads the decoded result.
// An untaken result in the result register stalls the frame stage, and with
// it the input, for as long as it waits. Reset is synchronous, active low; it
// clears the CRC, counts, valid flags and configuration registers to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module modbus_rtu_response_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mrd_pkg::ByteW-1:0]     s_tdata,   // [7:0] rx_byte
    input  logic                          s_tuser,   // [0] command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] frame_kind, [10:3] slave_address, [18:11] function_code,
    // [29:19] frame_length, [45:30] station_word, [53:46] register_index,
    // [69:54] register_value, [71:70] zero
    output logic [mrd_pkg::OutDataW-1:0]  m_tdata,
    input  logic                          cfg_we,
    input  logic [mrd_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [mrd_pkg::CfgW-1:0]      cfg_wdata
);
    import mrd_pkg::*;

    logic              word_valid;
    logic [ByteW-1:0]  word_byte;
    logic              word_cmd;
    logic              step;
    logic              out_busy;
    logic              res_valid;
    frame_result_t     result;
    frame_cfg_t        cfg;

    logic [IdleW-1:0]  idle_timeout_reg;
    logic [CountW-1:0] overflow_reg;
    logic [CountW-1:0] long_frame_reg;

    // Configuration registers; unlisted indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg <= IdleTimeoutReset;
            overflow_reg     <= OverflowReset;
            long_frame_reg   <= LongFrameReset;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_wdata;
                REG_OVERFLOW:     overflow_reg     <= cfg_wdata[CountW-1:0];
                REG_LONG_FRAME:   long_frame_reg   <= cfg_wdata[CountW-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.idle_timeout   = idle_timeout_reg;
    assign cfg.overflow_limit = overflow_reg;
    assign cfg.long_threshold = long_frame_reg;

    // Advance a word whenever the result register can take a result
    assign step = word_valid && !out_busy;

    mrd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (step),
        .word_valid (word_valid),
        .word_byte  (word_byte),
        .word_cmd   (word_cmd)
    );

    mrd_frame u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .word_byte (word_byte),
        .word_cmd  (word_cmd),
        .cfg       (cfg),
        .res_valid (res_valid),
        .result    (result)
    );

    mrd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .result   (result),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== verif/modbus_rtu_response_deframer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_rtu_response_deframer_test: self-checking bench for the deframer
// Drives received bytes and idle ticks through the input stream. Several
// register settings are covered, the extremes among them. Every reported
// response is compared against a cycle-free model of the frame tracker
// (running CRC, byte count, header bytes, idle count).
// ----------------------------------------------------------------------------
module modbus_rtu_response_deframer_test;
    import mrd_pkg::*;

    localparam int ClockHalf      = 4;
    localparam int ResetCycles    = 10;
    localparam int SettleCycles   = 8;
    localparam int LongHoldCycles = 400;
    localparam int StallLimit     = 5000;
    localparam int RandomWords    = 250;

    // Index that maps to no register; writes there must change nothing
    localparam logic [CfgIndexW-1:0] RegUnused = 2'd3;

    // Tracks one response frame and holds the responses still due
    class response_scoreboard;
        logic [IdleW-1:0]  idle_timeout;
        logic [CountW-1:0] overflow_limit;
        logic [CountW-1:0] long_threshold;
        logic [CrcW-1:0]   running_crc;
        logic [CountW-1:0] frame_bytes;
        logic [IdleW-1:0]  idle_ticks;
        logic [ByteW-1:0]  header_bytes [HeaderN];
        frame_result_t     expected_responses [$];
        int                errors;

        function new();
            idle_timeout   = IdleTimeoutReset;
            overflow_limit = OverflowReset;
            long_threshold = LongFrameReset;
            errors         = 0;
            foreach (header_bytes[i]) header_bytes[i] = '0;
            clear_frame();
        endfunction

        function void clear_frame();
            running_crc = CrcInit;
            frame_bytes = '0;
            idle_ticks  = '0;
        endfunction

        // Shift one byte through the reflected CRC-16, LSB first
        function logic [CrcW-1:0] crc_next(logic [CrcW-1:0] crc, logic [ByteW-1:0] b);
            logic [CrcW-1:0] acc;
            logic            lsb;
            acc = crc;
            for (int k = 0; k < ByteW; k++) begin
                lsb = acc[0] ^ b[k];
                acc = {1'b0, acc[CrcW-1:1]};
                if (lsb) acc = acc ^ CrcPoly;
            end
            return acc;
        endfunction

        // Header bytes past the end of a short frame read as zero
        function logic [ByteW-1:0] header_at(int pos);
            return (pos < frame_bytes) ? header_bytes[HeaderIdxW'(pos)] : '0;
        endfunction

        function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgW-1:0] val);
            case (idx)
                REG_IDLE_TIMEOUT: idle_timeout = val;
                REG_OVERFLOW:     overflow_limit = val[CountW-1:0];
                REG_LONG_FRAME:   long_threshold = val[CountW-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        // Advance the frame by one accepted input word
        function void note_word(command_t cmd, logic [ByteW-1:0] b);
            frame_result_t resp;
            frame_kind_t   kind;
            logic [ByteW-1:0] func;
            if (cmd == CMD_TICK) begin
                if (frame_bytes == 0) return;
                if (idle_ticks != IdleMax) idle_ticks++;
                if (idle_ticks >= idle_timeout) clear_frame();
                return;
            end
            idle_ticks  = '0;
            running_crc = crc_next(running_crc, b);
            if (frame_bytes < HeaderN) header_bytes[frame_bytes[HeaderIdxW-1:0]] = b;
            if (frame_bytes != CountMax) frame_bytes++;

            // CRC match wins over the overflow check
            if (frame_bytes > MinFrame && running_crc == '0) begin
                func = header_at(1);
                if (func == FuncRead) begin
                    if (frame_bytes > long_threshold)
                        kind = (frame_bytes == LenMeter) ? KIND_METER : KIND_BAD_LEN;
                    else
                        kind = (frame_bytes == LenPoll) ? KIND_POLL : KIND_BAD_LEN;
                end else if (func == FuncWrite) begin
                    kind = (frame_bytes == LenEcho) ? KIND_ECHO : KIND_BAD_LEN;
                end else begin
                    kind = KIND_UNKNOWN;
                end
                resp.frame_kind     = kind;
                resp.slave_address  = header_at(0);
                resp.function_code  = func;
                resp.frame_length   = frame_bytes;
                resp.station_word   = {header_at(3), header_at(4)};
                resp.register_index = header_at(3);
                resp.register_value = {header_at(4), header_at(5)};
                expected_responses.push_back(resp);
                clear_frame();
                return;
            end
            if (frame_bytes > overflow_limit) clear_frame();
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %h actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        // Compare one reported response with the oldest one due
        function void check_response(logic [OutDataW-1:0] word);
            frame_result_t want;
            if (expected_responses.size() == 0) begin
                $display("%0t: response with none due: expected none actual %h", $time, word);
                errors++;
                return;
            end
            want = expected_responses.pop_front();
            compare("frame_kind", 16'(want.frame_kind), 16'(word[2:0]));
            compare("slave_address", 16'(want.slave_address), 16'(word[10:3]));
            compare("function_code", 16'(want.function_code), 16'(word[18:11]));
            compare("frame_length", 16'(want.frame_length), 16'(word[29:19]));
            compare("station_word", want.station_word, word[45:30]);
            compare("register_index", 16'(want.register_index), 16'(word[53:46]));
            compare("register_value", want.register_value, word[69:54]);
            compare("padding", 16'h0000, 16'(word[71:70]));
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [ByteW-1:0]       s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OutDataW-1:0]    m_tdata;
    logic                   cfg_we;
    logic [CfgIndexW-1:0]   cfg_index;
    logic [CfgW-1:0]        cfg_wdata;

    response_scoreboard sb = new();
    int  burst_left = 0;
    int  words_sent = 0;
    int  stall_cycles = 0;
    bit  long_hold_req = 1'b0;

    modbus_rtu_response_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #ClockHalf aclk = 1'b1;
        #ClockHalf aclk = 1'b0;
    end

    // Check every response taken
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_response(m_tdata);
    end

    // Give up when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == StallLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: stall in changing modes, or hold off entirely on request
    initial begin
        int mode;
        int span;
        int rx_phase;
        mode = 0;
        span = 0;
        rx_phase = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LongHoldCycles) @(posedge aclk);
                long_hold_req = 1'b0;
                m_tready <= 1'b1;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(8, 64);
                end
                span--;
                rx_phase = (rx_phase + 1) % 3;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (rx_phase == 0);
                endcase
            end
        end
    end

    // Offer one word, in bursts with random gaps, and wait until taken
    task automatic send_word(command_t cmd, logic [ByteW-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(cmd, b);
        words_sent++;
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_word(CMD_TICK, 8'($urandom));
    endtask

    task automatic send_junk(int n);
        repeat (n) send_word(CMD_BYTE, 8'($urandom));
    endtask

    // Send a frame of len bytes with its CRC; fill < 0 gives random payload
    task automatic send_frame(logic [ByteW-1:0] addr, logic [ByteW-1:0] func, int len,
                              int fill, bit good);
        logic [ByteW-1:0] body [$];
        logic [CrcW-1:0]  crc;
        int               pos;
        body.push_back(addr);
        if (len > 3) body.push_back(func);
        while (body.size() < len - 2) body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        crc = CrcInit;
        foreach (body[i]) crc = sb.crc_next(crc, body[i]);
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        // Flip one bit somewhere to break the CRC
        if (!good) begin
            pos = $urandom_range(0, len - 1);
            body[pos] = body[pos] ^ 8'(1 << $urandom_range(0, 7));
        end
        foreach (body[i]) send_word(CMD_BYTE, body[i]);
    endtask

    // Append the two bytes that zero the residue of the open frame
    task automatic close_frame();
        logic [CrcW-1:0] crc;
        crc = sb.running_crc;
        send_word(CMD_BYTE, crc[7:0]);
        send_word(CMD_BYTE, crc[15:8]);
    endtask

    // Get back to an empty frame: time it out when cheap, else close it
    task automatic settle_frame();
        int guard;
        guard = 0;
        while (sb.frame_bytes != 0 && guard < 40) begin
            if (sb.idle_timeout <= 16) send_word(CMD_TICK, 8'($urandom));
            else close_frame();
            guard++;
        end
    endtask

    // Stop offering and wait for every due response, then for the pipeline
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // Write all registers while idle; upper bits of short registers are junk
    task automatic program_regs(logic [IdleW-1:0] timeout, logic [CountW-1:0] ovf,
                                logic [CountW-1:0] thr);
        drain();
        write_reg(REG_IDLE_TIMEOUT, timeout);
        write_reg(REG_OVERFLOW, {5'($urandom), ovf});
        write_reg(REG_LONG_FRAME, {5'($urandom), thr});
        write_reg(RegUnused, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    // One randomly chosen sequence: mostly well-formed frames
    task automatic random_sequence();
        int pick;
        int sel;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            settle_frame();
            sel = $urandom_range(0, 19);
            if (sel < 6)       send_frame(8'($urandom), FuncRead, LenPoll, -1, 1'b1);
            else if (sel < 11) send_frame(8'($urandom), FuncWrite, LenEcho, -1, 1'b1);
            else if (sel < 12) send_frame(8'($urandom), FuncRead, LenMeter, -1, 1'b1);
            else if (sel < 15) send_frame(8'($urandom), FuncRead, $urandom_range(4, 60), -1, 1'b1);
            else if (sel < 17) send_frame(8'($urandom), FuncWrite, $urandom_range(4, 12), -1, 1'b1);
            else if (sel < 19) send_frame(8'($urandom), 8'($urandom), $urandom_range(4, 20), -1, 1'b1);
            else               send_frame(8'($urandom), FuncRead, $urandom_range(4, 6), -1, 1'b1);
        end else if (pick < 72) begin
            settle_frame();
            send_frame(8'($urandom), ($urandom_range(0, 1) == 0) ? FuncRead : FuncWrite,
                       $urandom_range(4, 45), -1, 1'b0);
        end else if (pick < 84) begin
            send_ticks($urandom_range(1, 40));
        end else if (pick < 95) begin
            send_junk($urandom_range(1, 12));
        end else begin
            drain();
        end
    endtask

    // Random settings, then random traffic for about n words
    task automatic random_phase(int n);
        logic [IdleW-1:0]  timeout;
        logic [CountW-1:0] ovf;
        logic [CountW-1:0] thr;
        int                start;
        case ($urandom_range(0, 2))
            0:       timeout = IdleW'($urandom_range(1, 8));
            1:       timeout = IdleW'($urandom_range(9, 40));
            default: timeout = IdleW'($urandom_range(41, 3000));
        endcase
        ovf = ($urandom_range(0, 3) == 0) ? CountW'($urandom_range(8, 60))
                                          : CountW'($urandom_range(206, 2047));
        case ($urandom_range(0, 5))
            0:       thr = 11'd40;
            1:       thr = 11'd41;
            2:       thr = LongFrameReset;
            3:       thr = 11'd204;
            4:       thr = 11'd205;
            default: thr = CountW'($urandom_range(0, 2047));
        endcase
        program_regs(timeout, ovf, thr);
        start = words_sent;
        while (words_sent - start < n) random_sequence();
    endtask

    initial begin
        int start;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_BYTE;
        cfg_we    <= 1'b0;
        cfg_index <= REG_IDLE_TIMEOUT;
        cfg_wdata <= '0;
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: every kind, short headers, sub-minimum and bad frames
        send_ticks(2);
        send_frame(8'hFF, FuncWrite, LenEcho, 8'hFF, 1'b1);
        send_frame(8'h00, FuncWrite, LenEcho, 8'h00, 1'b1);
        send_frame(8'($urandom), FuncRead, LenPoll, -1, 1'b1);
        send_frame(8'($urandom), FuncRead, 4, -1, 1'b1);
        send_frame(8'($urandom), FuncWrite, 5, -1, 1'b1);
        send_frame(8'($urandom), 8'h10, 6, -1, 1'b1);
        send_frame(8'($urandom), 8'h00, 3, -1, 1'b1);
        settle_frame();
        send_frame(8'($urandom), FuncWrite, LenEcho, -1, 1'b0);
        settle_frame();
        send_frame(8'($urandom), FuncRead, LenMeter, -1, 1'b1);

        // Short timeout, lowest listed overflow, zero threshold
        program_regs(16'd3, 11'd8, 11'd0);
        send_junk(2);
        send_ticks(2);
        send_junk(1);
        send_ticks(2);
        settle_frame();
        send_frame(8'($urandom), FuncWrite, LenEcho, -1, 1'b1);
        send_junk(9);
        settle_frame();
        send_frame(8'($urandom), FuncRead, LenPoll, -1, 1'b1);
        settle_frame();
        send_frame(8'($urandom), FuncRead, 4, -1, 1'b1);
        send_frame(8'($urandom), FuncRead, LenEcho, -1, 1'b1);

        // Zero timeout, overflow off, top threshold; then close a long run of junk
        program_regs(16'd0, CountMax, CountMax);
        send_junk(2);
        send_ticks(1);
        send_frame(8'($urandom), FuncRead, LenMeter, -1, 1'b1);
        send_frame(8'($urandom), FuncRead, LenPoll, -1, 1'b1);
        send_junk(40);
        close_frame();
        settle_frame();

        // Longest timeout: a partial frame outlives a run of ticks
        program_regs(IdleMax, OverflowReset, 11'd204);
        send_junk(3);
        send_ticks(40);
        send_frame(8'($urandom), FuncWrite, LenEcho, -1, 1'b1);

        // Overflow limit below a minimal frame
        program_regs(16'd2, 11'd3, 11'd5);
        send_frame(8'($urandom), FuncRead, 4, -1, 1'b1);
        send_frame(8'($urandom), FuncWrite, LenEcho, -1, 1'b1);
        settle_frame();
        send_frame(8'($urandom), 8'($urandom), 4, -1, 1'b1);

        // Random part; the first phase opens with a long receiver hold-off
        program_regs(16'd5, OverflowReset, LongFrameReset);
        start = words_sent;
        settle_frame();
        long_hold_req = 1'b1;
        repeat (60) send_frame(8'($urandom), 8'($urandom), 4, -1, 1'b1);
        while (words_sent - start < RandomWords / 5) random_sequence();
        repeat (4) random_phase(RandomWords / 5);

        drain();
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== modbus_rtu_response_deframer.f =====
rtl/mrd_pkg.sv
rtl/mrd_in_reg.sv
rtl/mrd_frame.sv
rtl/mrd_out_reg.sv
rtl/modbus_rtu_response_deframer.sv
verif/modbus_rtu_response_deframer_test.sv
